// ===== design/bcpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpf_pkg: shared definitions for the contour pixel finder
// Register codes, field widths, reset sizes and the result record.
// ----------------------------------------------------------------------------
package bcpf_pkg;

  // fixed field widths
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned COORD_W    = 10;

  // default storage limits
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DEF_MAX_WIDTH  = 1024;

  // frame size after reset and the smallest usable size
  localparam int unsigned FRAME_HEIGHT_RST = 480;
  localparam int unsigned FRAME_WIDTH_RST  = 640;
  localparam int unsigned MIN_SIZE         = 3;

  // result queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // configuration register indexes
  typedef enum logic {
    CFG_FRAME_HEIGHT = 1'b0,
    CFG_FRAME_WIDTH  = 1'b1
  } cfg_index_e;

  // one result beat
  typedef struct packed {
    logic               is_contour;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               frame_end;
  } result_t;

  // result handed from the front to the queue
  typedef struct packed {
    logic    valid;
    result_t data;
  } result_push_t;

  // size register value saturated to [MIN_SIZE, max_size], minus one
  function automatic int unsigned size_last(logic [CFG_DATA_W-1:0] v,
                                            int unsigned max_size);
    int unsigned val;
    val = int'(v);
    if (val < MIN_SIZE) begin
      return MIN_SIZE - 1;
    end else if (val > max_size) begin
      return max_size - 1;
    end
    return val - 1;
  endfunction

endpackage

// ===== design/bcpf_if.sv =====
// ----------------------------------------------------------------------------
// bcpf_if: stream channels of the contour pixel finder
// Valid/ready channels for the mask pixels and the contour results.
// ----------------------------------------------------------------------------

// mask pixel channel
interface bcpf_pixel_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// contour result channel
interface bcpf_result_if import bcpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               is_contour;
  logic [COORD_W-1:0] contour_x;
  logic [COORD_W-1:0] contour_y;
  logic               frame_end;

  modport source (output valid, output is_contour, output contour_x,
                  output contour_y, output frame_end, input ready);
  modport sink   (input valid, input is_contour, input contour_x,
                  input contour_y, input frame_end, output ready);
endinterface

// ===== design/bcpf_ram.sv =====
// ----------------------------------------------------------------------------
// bcpf_ram: generic RAM, one write port, two registered read ports
// Contents are not reset.
// ----------------------------------------------------------------------------
module bcpf_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                         rdata_a_o,
  output logic [WIDTH-1:0]                         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== design/bcpf_front.sv =====
// ----------------------------------------------------------------------------
// bcpf_front: pixel intake, line store and neighbourhood check
// Tracks the frame position, reads the two stored columns at the incoming
// row, judges the centre pixel in the following cycle and pushes results.
// ----------------------------------------------------------------------------
module bcpf_front import bcpf_pkg::*; #(
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcpf_pixel_if.sink            pix_i,
  input  logic                  cfg_we_i,
  input  cfg_index_e            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  room_i,
  output result_push_t          push_o
);

  localparam int unsigned YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RST_H_LAST = size_last(CFG_DATA_W'(FRAME_HEIGHT_RST), MAX_HEIGHT);
  localparam int unsigned RST_W_LAST = size_last(CFG_DATA_W'(FRAME_WIDTH_RST), MAX_WIDTH);

  // store entry: bit 1 older column, bit 0 previous column
  localparam int unsigned PREV  = 0;
  localparam int unsigned OLDER = 1;

  logic [YW-1:0] h_last_q, h_last_d;
  logic [XW-1:0] w_last_q, w_last_d;
  logic [YW-1:0] row_q, row_d;
  logic [XW-1:0] col_q, col_d;
  logic          clearing_q, clearing_d;
  logic [YW-1:0] clr_addr_q, clr_addr_d;

  logic          s2_valid_q;
  logic [YW-1:0] s2_row_q;
  logic [XW-1:0] s2_x_q;
  logic          s2_pixel_q;
  logic          s2_judge_q;
  logic          s2_last_q;
  logic          above_q;

  logic          accept;
  logic          judge;
  logic          last;
  logic          found;
  logic          ram_we;
  logic [YW-1:0] ram_waddr;
  logic [1:0]    ram_wdata;
  logic [1:0]    rd_a;
  logic [1:0]    rd_b;

  // intake handshake
  assign pix_i.ready = ~clearing_q & room_i;
  assign accept      = pix_i.valid & pix_i.ready;

  // classification of the incoming position
  assign judge = (col_q >= XW'(2)) && (row_q != '0) && (row_q != h_last_q);
  assign last  = (col_q == w_last_q) && (row_q == h_last_q);

  // frame size registers and position counters
  always_comb begin
    h_last_d   = h_last_q;
    w_last_d   = w_last_q;
    row_d      = row_q;
    col_d      = col_q;
    clearing_d = clearing_q;
    clr_addr_d = clr_addr_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == YW'(MAX_HEIGHT - 1)) begin
        clearing_d = 1'b0;
      end
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_HEIGHT: h_last_d = YW'(size_last(cfg_data_i, MAX_HEIGHT));
        CFG_FRAME_WIDTH:  w_last_d = XW'(size_last(cfg_data_i, MAX_WIDTH));
        default:          ;
      endcase
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (row_q == h_last_q) begin
        row_d = '0;
        col_d = (col_q == w_last_q) ? '0 : col_q + 1'b1;
      end else begin
        row_d = row_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_last_q   <= YW'(RST_H_LAST);
      w_last_q   <= XW'(RST_W_LAST);
      row_q      <= '0;
      col_q      <= '0;
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
      s2_valid_q <= 1'b0;
      above_q    <= 1'b0;
    end else begin
      h_last_q   <= h_last_d;
      w_last_q   <= w_last_d;
      row_q      <= row_d;
      col_q      <= col_d;
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
      s2_valid_q <= accept;
      if (s2_valid_q) begin
        above_q <= rd_a[PREV];
      end
    end
  end

  // second stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_row_q   <= row_q;
      s2_x_q     <= col_q - 1'b1;
      s2_pixel_q <= pix_i.pixel;
      s2_judge_q <= judge;
      s2_last_q  <= last;
    end
  end

  // line store: clearing pass first, then column shift at the judged row
  assign ram_we    = clearing_q | s2_valid_q;
  assign ram_waddr = clearing_q ? clr_addr_q : s2_row_q;
  assign ram_wdata = clearing_q ? 2'b00 : {rd_a[PREV], s2_pixel_q};

  bcpf_ram #(
    .WIDTH (2),
    .DEPTH (MAX_HEIGHT)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (accept),
    .raddr_a_i (row_q),
    .raddr_b_i (row_q + 1'b1),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // neighbourhood check on the centre pixel
  assign found = s2_judge_q & rd_a[PREV] &
                 ((rd_a[OLDER] ^ s2_pixel_q) | (above_q ^ rd_b[PREV]));

  // result towards the queue
  always_comb begin
    push_o.valid           = s2_valid_q & (found | s2_last_q);
    push_o.data.is_contour = found;
    push_o.data.x          = found ? COORD_W'(s2_x_q) : '0;
    push_o.data.y          = found ? COORD_W'(s2_row_q) : '0;
    push_o.data.frame_end  = s2_last_q;
  end

endmodule

// ===== design/bcpf_back.sv =====
// ----------------------------------------------------------------------------
// bcpf_back: result queue and output channel
// Small FIFO that parts the pixel side from the result side.
// ----------------------------------------------------------------------------
module bcpf_back import bcpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  result_push_t  push_i,
  output logic          room_o,
  bcpf_result_if.source res_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  result_t       entries_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q;
  logic [PW-1:0] rptr_q;
  logic [PW:0]   count_q;
  logic          pop;

  // room for the beat in flight plus a new one
  assign room_o = count_q <= (PW + 1)'(QUEUE_DEPTH - 2);

  // output side
  assign pop              = res_o.valid & res_o.ready;
  assign res_o.valid      = count_q != '0;
  assign res_o.is_contour = entries_q[rptr_q].is_contour;
  assign res_o.contour_x  = entries_q[rptr_q].x;
  assign res_o.contour_y  = entries_q[rptr_q].y;
  assign res_o.frame_end  = entries_q[rptr_q].frame_end;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entries_q[wptr_q] <= push_i.data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({push_i.valid, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== design/binary_contour_pixel_finder_unit.sv =====
// ----------------------------------------------------------------------------
// binary_contour_pixel_finder_unit: streaming 3x3 contour finder
// Reports set interior pixels of a column-major binary mask whose
// horizontal or vertical neighbours differ, plus a frame-end beat.
// ----------------------------------------------------------------------------
// Takes one mask pixel per clock when not stalled, rows fastest then columns,
// and gives a result beat for each contour pixel found and one for the
// frame's last pixel. After reset the line store is cleared through all
// MAX_HEIGHT entries, during which no pixel is taken (configuration writes
// still are). A pixel's result passes the second-stage register and the
// result queue before it leaves; the single line store access per pixel
// sets the rate, and a four-beat result queue lets the two sides stall on their own.
// Writing either size register restarts the frame position at column 0,
// row 0; sizes are saturated to 3..MAX_HEIGHT and 3..MAX_WIDTH.
module binary_contour_pixel_finder_unit import bcpf_pkg::*; #(
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bcpf_pixel_if.sink            pix_i,
  bcpf_result_if.source         res_o,
  input  logic                  cfg_we_i,
  input  cfg_index_e            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  result_push_t push;
  logic         room;

  // intake, line store and check
  bcpf_front #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .room_i      (room),
    .push_o      (push)
  );

  // result queue and output
  bcpf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule

// ===== bench/binary_contour_pixel_finder_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_contour_pixel_finder_unit_tb: self-checking bench for the contour finder
// Streams binary masks through the pixel channel with random gaps and random
// result back-pressure, keeps its own model of the line stores and frame
// position, and checks every result beat field by field in order.
// ----------------------------------------------------------------------------
module binary_contour_pixel_finder_unit_tb;
  import bcpf_pkg::*;

  localparam int unsigned MAX_H         = DEF_MAX_HEIGHT;
  localparam int unsigned MAX_W         = DEF_MAX_WIDTH;
  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned SETTLE_CYCLES = 8;

  // 3x3 masks, bit i is the i-th pixel in column-major order
  localparam logic [8:0] MASK_SIDE_DIFF = 9'b010010000;
  localparam logic [8:0] MASK_VERT_DIFF = 9'b000011000;
  localparam logic [8:0] MASK_ALL_SET   = 9'h1FF;

  typedef enum int unsigned {
    MASK_NOISE,
    MASK_BLOCK,
    MASK_FULL,
    MASK_EMPTY
  } mask_kind_e;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  cfg_index_e            cfg_index_i = CFG_FRAME_HEIGHT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  bcpf_pixel_if  pix_if ();
  bcpf_result_if res_if ();

  // back-to-back stretches on either side
  bit burst_src  = 1'b0;
  bit burst_sink = 1'b0;

  int unsigned err_count = 0;

  // model state: line stores, frame position, size registers
  bit                    prev_col  [MAX_H];
  bit                    older_col [MAX_H];
  bit                    above_bit = 1'b0;
  int unsigned           col_pos   = 0;
  int unsigned           row_pos   = 0;
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(FRAME_HEIGHT_RST);
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(FRAME_WIDTH_RST);

  result_t pending_contours [$];

  binary_contour_pixel_finder_unit #(
    .MAX_HEIGHT(MAX_H),
    .MAX_WIDTH (MAX_W)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .pix_i      (pix_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #2 clk = ~clk;

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned sat_size(input logic [CFG_DATA_W-1:0] raw,
                                           input int unsigned top);
    if (raw < MIN_SIZE) return MIN_SIZE;
    if (raw > top) return top;
    return int'(raw);
  endfunction

  // judge the pixel left of the incoming one and shift the line stores
  task automatic judge_pixel(input bit right);
    int unsigned h;
    int unsigned w;
    int unsigned y;
    int unsigned cx;
    bit          found;
    bit          last;
    result_t     r;
    h     = sat_size(height_reg, MAX_H);
    w     = sat_size(width_reg, MAX_W);
    y     = (row_pos >= h) ? h - 1 : row_pos;
    cx    = (col_pos >= w) ? w - 1 : col_pos;
    found = 1'b0;
    if (cx >= 2 && y >= 1 && y + 1 < h) begin
      found = prev_col[y] && (older_col[y] != right || above_bit != prev_col[y + 1]);
    end
    above_bit    = prev_col[y];
    older_col[y] = prev_col[y];
    prev_col[y]  = right;
    last = (cx == w - 1) && (y == h - 1);
    if (found || last) begin
      r.is_contour = found;
      r.x          = found ? COORD_W'(cx - 1) : '0;
      r.y          = found ? COORD_W'(y) : '0;
      r.frame_end  = last;
      pending_contours = {pending_contours, r};
    end
    // step to the next row, wrapping into the next column
    if (y + 1 >= h) begin
      row_pos = 0;
      col_pos = (cx + 1 >= w) ? 0 : cx + 1;
    end else begin
      row_pos = y + 1;
      col_pos = cx;
    end
  endtask

  // predict on every pixel beat, check every result beat against the oldest
  always @(posedge clk) begin : track_beats
    result_t want;
    if (rst_n) begin
      if (pix_if.valid && pix_if.ready) judge_pixel(pix_if.pixel);
      if (res_if.valid && res_if.ready) begin
        if (pending_contours.size() == 0) begin
          report_error($sformatf("unexpected result: contour %0b x %0d y %0d end %0b",
                                 res_if.is_contour, res_if.contour_x, res_if.contour_y,
                                 res_if.frame_end));
        end else begin
          want = pending_contours.pop_front();
          if (res_if.is_contour !== want.is_contour)
            report_error($sformatf("is_contour got %0b expected %0b",
                                   res_if.is_contour, want.is_contour));
          if (res_if.contour_x !== want.x)
            report_error($sformatf("contour_x got %0d expected %0d",
                                   res_if.contour_x, want.x));
          if (res_if.contour_y !== want.y)
            report_error($sformatf("contour_y got %0d expected %0d",
                                   res_if.contour_y, want.y));
          if (res_if.frame_end !== want.frame_end)
            report_error($sformatf("frame_end got %0b expected %0b",
                                   res_if.frame_end, want.frame_end));
        end
      end
    end
  end

  // result side: random stall before each beat
  initial begin : result_ready
    int unsigned stall;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = burst_sink ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  // one pixel beat after a random gap
  task automatic send_pixel(input bit value);
    int unsigned gap;
    gap = burst_src ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel <= value;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  // hold the pixel side until every predicted result has come out
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_contours.size() != 0) @(posedge clk);
  endtask

  // drained and quiet, safe for a register write
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FRAME_HEIGHT) height_reg = value;
    else width_reg = value;
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  // stream a mask from the frame origin, optionally draining midway
  task automatic drive_mask(input int unsigned count, input int unsigned rows,
                            input int unsigned cols, input mask_kind_e kind,
                            input int unsigned density, input int unsigned pause_at);
    int unsigned x0;
    int unsigned x1;
    int unsigned y0;
    int unsigned y1;
    int unsigned x;
    int unsigned y;
    bit          px;
    x0 = $urandom_range(0, cols - 1);
    x1 = $urandom_range(x0, cols - 1);
    y0 = $urandom_range(0, rows - 1);
    y1 = $urandom_range(y0, rows - 1);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == pause_at) drain_results();
      x = (i / rows) % cols;
      y = i % rows;
      case (kind)
        MASK_NOISE: px = ($urandom_range(0, 99) < density);
        MASK_BLOCK: px = (x >= x0 && x <= x1 && y >= y0 && y <= y1) ^
                         ($urandom_range(0, 19) == 0);
        MASK_FULL:  px = 1'b1;
        default:    px = 1'b0;
      endcase
      send_pixel(px);
    end
  endtask

  task automatic send_pattern(input logic [8:0] pattern);
    for (int i = 0; i < 9; i++) send_pixel(pattern[i]);
  endtask

  // size register value, now and then out of range or at the limits
  function automatic logic [CFG_DATA_W-1:0] draw_size();
    case ($urandom_range(0, 11))
      0:       return CFG_DATA_W'($urandom_range(0, MIN_SIZE - 1));
      1:       return CFG_DATA_W'($urandom_range(MAX_H, 2047));
      2:       return CFG_DATA_W'(MIN_SIZE);
      3:       return CFG_DATA_W'($urandom_range(15, 40));
      default: return CFG_DATA_W'($urandom_range(4, 14));
    endcase
  endfunction

  // sizes left at reset, with one drain in the middle of the stream
  task automatic test_reset_size();
    drive_mask(1000, sat_size(height_reg, MAX_H), sat_size(width_reg, MAX_W),
               MASK_NOISE, 50, 500);
  endtask

  // 3x3 frames: side difference, flat frame, vertical difference
  task automatic test_smallest_frame();
    settle();
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(MIN_SIZE));
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MIN_SIZE));
    send_pattern(MASK_SIDE_DIFF);
    send_pattern(MASK_ALL_SET);
    // below-minimum values saturate back to 3x3
    settle();
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(CFG_FRAME_HEIGHT, '0);
    send_pattern(MASK_VERT_DIFF);
  endtask

  // random sizes and masks, whole, partial and repeated frames
  task automatic test_random_frames();
    int unsigned           sent;
    int unsigned           h;
    int unsigned           w;
    int unsigned           n;
    int unsigned           pick;
    logic [CFG_DATA_W-1:0] raw_h;
    logic [CFG_DATA_W-1:0] raw_w;
    mask_kind_e            kind;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      settle();
      raw_h = draw_size();
      raw_w = draw_size();
      pick  = $urandom_range(0, 9);
      if (pick < 5) begin
        write_reg(CFG_FRAME_HEIGHT, raw_h);
        write_reg(CFG_FRAME_WIDTH, raw_w);
      end else if (pick < 7) begin
        write_reg(CFG_FRAME_WIDTH, raw_w);
        write_reg(CFG_FRAME_HEIGHT, raw_h);
      end else if (pick < 9) begin
        write_reg(CFG_FRAME_HEIGHT, raw_h);
      end else begin
        write_reg(CFG_FRAME_WIDTH, raw_w);
      end
      h = sat_size(height_reg, MAX_H);
      w = sat_size(width_reg, MAX_W);
      n = h * w;
      if (n > 400) n = $urandom_range(50, 400);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      else if ($urandom_range(0, 3) == 0 && 2 * n <= 400) n = 2 * n;
      pick = $urandom_range(0, 9);
      if (pick < 5) kind = MASK_BLOCK;
      else if (pick < 8) kind = MASK_NOISE;
      else if (pick == 8) kind = MASK_FULL;
      else kind = MASK_EMPTY;
      burst_src  = ($urandom_range(0, 4) == 0);
      burst_sink = ($urandom_range(0, 4) == 0);
      drive_mask(n, h, w, kind, $urandom_range(10, 90),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : n);
      sent += n;
    end
    burst_src  = 1'b0;
    burst_sink = 1'b0;
  endtask

  initial begin
    pix_if.valid = 1'b0;
    pix_if.pixel = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_smallest_frame();
    test_random_frames();
    drain_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
